// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VDBS_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vdbs assertion failed");
`define VDBS_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vdbs assertion failed");
`else
`define VDBS_ASSERT_IMP(lbl, clk, rst, pre, post)
`define VDBS_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- rtl/core/vdbs_pkg.sv -----
// shared types and constants of the voice delta streamer
`timescale 1ns / 1ps
`default_nettype none
package vdbs_pkg;
  localparam int VOICE_BYTES     = 155;
  localparam int NAME_START      = 145;
  localparam int NAME_LENGTH     = 10;
  localparam int PARAM_MSG_BYTES = 7;
  localparam int DUMP_MSG_BYTES  = 163;
  localparam int MAX_PARAMS      = 64;
  localparam int DUMP_THR        = DUMP_MSG_BYTES / PARAM_MSG_BYTES;
  localparam int FREQ_AREA_END   = 126;
  localparam int OP_STRIDE       = 21;
  localparam int OP_COARSE       = 18;
  localparam int OP_FINE         = 19;
  localparam int OP_DETUNE       = 20;

  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_COMMIT = 3'd1;
  localparam logic [2:0] KIND_INVAL = 3'd2;
  localparam logic [2:0] KIND_FORCE = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic [1:0] REG_CHANNEL = 2'd0;
  localparam logic [1:0] REG_BUDGET  = 2'd1;
  localparam logic [1:0] REG_FREQ    = 2'd2;

  typedef struct packed {
    logic [4:0] channel;
    logic [6:0] limit;
    logic       freq_only;
  } vdbs_cfg_t;

  typedef struct packed {
    logic       tgt_we;
    logic       base_we;
    logic [7:0] waddr;
    logic [7:0] tgt_wdata;
    logic [7:0] base_wdata;
    logic [7:0] raddr;
  } vdbs_mem_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/vdbs_store.sv -----
// target and baseline voice memories
`timescale 1ns / 1ps
`default_nettype none
module vdbs_store (
  input  wire logic                   clk,
  input  wire vdbs_pkg::vdbs_mem_req_t mreq,
  output logic [7:0]                  t_rd,
  output logic [7:0]                  b_rd
);
  import vdbs_pkg::*;
  logic [7:0] tgt  [VOICE_BYTES];
  logic [7:0] base [VOICE_BYTES];

  always_ff @(posedge clk) begin
    if (mreq.tgt_we) begin
      tgt[mreq.waddr] <= mreq.tgt_wdata;
    end
    if (mreq.base_we) begin
      base[mreq.waddr] <= mreq.base_wdata;
    end
    t_rd <= tgt[mreq.raddr];
    b_rd <= base[mreq.raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/vdbs_cfg.sv -----
// apb configuration registers with clamping
`timescale 1ns / 1ps
`default_nettype none
module vdbs_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output vdbs_pkg::vdbs_cfg_t cfg
);
  import vdbs_pkg::*;
  logic [4:0] midi_channel;
  logic [6:0] max_params_per_tick;
  logic       stream_freq_only;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel        <= 5'd1;
      max_params_per_tick <= 7'd1;
      stream_freq_only    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CHANNEL: midi_channel        <= pwdata[4:0];
        REG_BUDGET:  max_params_per_tick <= pwdata[6:0];
        REG_FREQ:    stream_freq_only    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL: prdata = {27'd0, midi_channel};
      REG_BUDGET:  prdata = {25'd0, max_params_per_tick};
      REG_FREQ:    prdata = {31'd0, stream_freq_only};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (midi_channel == 5'd0) cfg.channel = 5'd1;
    else if (midi_channel > 5'd16) cfg.channel = 5'd16;
    else cfg.channel = midi_channel;
    if (max_params_per_tick == 7'd0) cfg.limit = 7'd1;
    else if (max_params_per_tick > 7'(MAX_PARAMS)) cfg.limit = 7'(MAX_PARAMS);
    else cfg.limit = max_params_per_tick;
    cfg.freq_only = stream_freq_only;
  end
endmodule
`default_nettype wire

// ----- rtl/core/vdbs_seq.sv -----
// scan sequencer: diff count, decision, emission and dump copy
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vdbs_seq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  byte_index,
  input  wire logic [7:0]  byte_value,
  input  wire logic        force_commit,
  input  wire logic        live_all,
  input  wire logic        notes_sounding,
  input  wire vdbs_pkg::vdbs_cfg_t cfg,
  output vdbs_pkg::vdbs_mem_req_t mreq,
  input  wire logic [7:0]  t_rd,
  input  wire logic [7:0]  b_rd,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic             full_dump,
  output logic [7:0]       param_index,
  output logic [7:0]       param_value,
  output logic [4:0]       out_channel,
  output logic             last_of_tick
);
  import vdbs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD1    = 9'b000000010,
    S_EV1    = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_RD2    = 9'b000010000,
    S_EV2    = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_DUMP   = 9'b010000000,
    S_CPY    = 9'b100000000
  } state_t;

  state_t     state;
  logic       rd_wait;
  logic [7:0] idx;
  logic [4:0] opc;
  logic       target_valid, baseline_valid, commit_pending, all_params_pending;
  logic       sounding, fonly;
  logic [7:0] diffs, nf, emittable;
  logic [6:0] total, n, en;

  logic is_name, is_freq, differ, emit_ok, free, emit, at_end, acc, out_load;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign free     = !m_tvalid || m_tready;
  assign is_name  = (idx >= 8'(NAME_START)) && (idx < 8'(NAME_START + NAME_LENGTH));
  assign is_freq  = (idx < 8'(FREQ_AREA_END)) && ((opc == 5'(OP_COARSE)) ||
                    (opc == 5'(OP_FINE)) || (opc == 5'(OP_DETUNE)));
  assign differ   = (t_rd != b_rd) && !is_name;
  assign emit_ok  = differ && (!fonly || is_freq) && (n < total);
  assign emit     = (state == S_EV2) && emit_ok && free;
  assign at_end   = (idx == 8'(VOICE_BYTES - 1));
  assign out_load = emit || ((state == S_DUMP) && free);

  always_comb begin
    mreq.raddr      = idx;
    mreq.waddr      = idx;
    mreq.tgt_we     = 1'b0;
    mreq.base_we    = 1'b0;
    mreq.tgt_wdata  = byte_value;
    mreq.base_wdata = t_rd;
    if (state == S_IDLE) begin
      mreq.waddr      = byte_index;
      mreq.base_wdata = byte_value;
      if (acc && byte_index < 8'(VOICE_BYTES)) begin
        mreq.tgt_we  = (kind == KIND_LOAD) || (kind == KIND_FORCE);
        mreq.base_we = (kind == KIND_FORCE);
      end
    end else if (emit) begin
      mreq.base_we = 1'b1;
    end else if (state == S_CPY && !rd_wait) begin
      mreq.base_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      rd_wait            <= 1'b0;
      target_valid       <= 1'b0;
      baseline_valid     <= 1'b0;
      commit_pending     <= 1'b0;
      all_params_pending <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      case (state)
        S_IDLE: begin
          idx <= 8'd0;
          opc <= 5'd0;
          if (acc) begin
            case (kind)
              KIND_COMMIT: begin
                target_valid <= 1'b1;
                if (force_commit) commit_pending <= 1'b1;
                if (live_all) all_params_pending <= 1'b1;
              end
              KIND_INVAL: begin
                baseline_valid     <= 1'b0;
                commit_pending     <= 1'b1;
                all_params_pending <= 1'b0;
              end
              KIND_FORCE: begin
                baseline_valid     <= 1'b1;
                target_valid       <= 1'b1;
                commit_pending     <= 1'b0;
                all_params_pending <= 1'b0;
              end
              KIND_TICK: begin
                if (target_valid) begin
                  if (!baseline_valid) begin
                    state <= S_DUMP;
                  end else begin
                    sounding  <= notes_sounding;
                    fonly     <= notes_sounding && cfg.freq_only && !all_params_pending;
                    diffs     <= 8'd0;
                    nf        <= 8'd0;
                    emittable <= 8'd0;
                    state     <= S_RD1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RD1: state <= S_EV1;
        S_EV1: begin
          if (differ) begin
            diffs <= diffs + 8'd1;
            if (!is_freq) nf <= nf + 8'd1;
            if (!fonly || is_freq) emittable <= emittable + 8'd1;
          end
          if (at_end) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx + 8'd1;
            opc   <= (opc == 5'(OP_STRIDE - 1)) ? 5'd0 : opc + 5'd1;
            state <= S_RD1;
          end
        end
        S_DECIDE: begin
          idx <= 8'd0;
          opc <= 5'd0;
          n   <= 7'd0;
          en  <= 7'd0;
          total <= (emittable > {1'b0, cfg.limit}) ? cfg.limit : emittable[6:0];
          if (diffs == 8'd0) begin
            commit_pending     <= 1'b0;
            all_params_pending <= 1'b0;
            state              <= S_IDLE;
          end else if (!sounding && (commit_pending ||
                       ({5'd0, diffs} > 13'(DUMP_THR)))) begin
            state <= S_DUMP;
          end else if (emittable == 8'd0) begin
            state <= S_FIN;
          end else begin
            state <= S_RD2;
          end
        end
        S_RD2: state <= S_EV2;
        S_EV2: begin
          if (!emit_ok || free) begin
            if (emit) begin
              full_dump    <= 1'b0;
              param_index  <= idx;
              param_value  <= t_rd;
              out_channel  <= cfg.channel;
              last_of_tick <= (n + 7'd1 == total);
              n            <= n + 7'd1;
              if (!is_freq) en <= en + 7'd1;
            end
            if (at_end || (emit && (n + 7'd1 == total))) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + 8'd1;
              opc   <= (opc == 5'(OP_STRIDE - 1)) ? 5'd0 : opc + 5'd1;
              state <= S_RD2;
            end
          end
        end
        S_FIN: begin
          if (diffs == {1'b0, n}) commit_pending <= 1'b0;
          if (nf == {1'b0, en}) all_params_pending <= 1'b0;
          state <= S_IDLE;
        end
        S_DUMP: begin
          if (free) begin
            full_dump          <= 1'b1;
            param_index        <= 8'd0;
            param_value        <= 8'd0;
            out_channel        <= cfg.channel;
            last_of_tick       <= 1'b1;
            baseline_valid     <= 1'b1;
            commit_pending     <= 1'b0;
            all_params_pending <= 1'b0;
            idx                <= 8'd0;
            rd_wait            <= 1'b1;
            state              <= S_CPY;
          end
        end
        S_CPY: begin
          rd_wait <= !rd_wait;
          if (!rd_wait) begin
            if (at_end) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 8'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VDBS_ASSERT_IMP(a_emit_budget, clk, rst, emit, n < total)
  `VDBS_ASSERT_IMP(a_fin_count, clk, rst, state == S_FIN, {1'b0, n} <= diffs)
  `VDBS_ASSERT_IMP(a_base_wr, clk, rst, mreq.base_we && state != S_IDLE,
                   state == S_EV2 || state == S_CPY)
  `VDBS_ASSERT_NXT(a_dump_valid, clk, rst, state == S_DUMP && free, baseline_valid)
endmodule
`default_nettype wire

// ----- rtl/core/voice_delta_budget_streamer_core.sv -----
// top level of the voice delta budget streamer
// usage:
// - slave stream: s_tuser carries the kind, s_tdata the byte index, value and flags
// - master stream: one request per result; s_tlast-style m_tlast marks the last of a
//   tick, m_tuser set means a whole-voice dump instead of an (index, value) pair
// - apb port: channel at 0x0, per-tick budget at 0x4, freq-only mode at 0x8
// - load, commit, invalidate and force requests are handled in the idle state
// - a tick takes a diff pass over the voice memories, with a read and an evaluate
//   state per byte, then an emit pass that ends early once the budget is spent, or
//   a dump copy; the voice memories share one read address
// - s_tready is low while a tick is being worked on
// - when m_tready is low the emit pass holds at the waiting pair
// - reset clears the valid and pending flags and sets the apb registers to their
//   defaults; the voice memories are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module voice_delta_budget_streamer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // byte_index, byte_value, force_commit, live_all, notes_sounding
  input  wire logic [2:0]  s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // param_index, param_value, out_channel
  output logic             m_tuser,  // full_dump
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import vdbs_pkg::*;
  vdbs_cfg_t     cfg;
  vdbs_mem_req_t mreq;
  logic [7:0]    t_rd, b_rd;
  logic [7:0]    param_index, param_value;
  logic [4:0]    out_channel;

  vdbs_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  vdbs_store u_store (.clk(clk), .mreq(mreq), .t_rd(t_rd), .b_rd(b_rd));

  vdbs_seq u_seq (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .kind(s_tuser), .byte_index(s_tdata[7:0]), .byte_value(s_tdata[15:8]),
    .force_commit(s_tdata[16]), .live_all(s_tdata[17]), .notes_sounding(s_tdata[18]),
    .cfg(cfg), .mreq(mreq), .t_rd(t_rd), .b_rd(b_rd),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .full_dump(m_tuser),
    .param_index(param_index), .param_value(param_value),
    .out_channel(out_channel), .last_of_tick(m_tlast)
  );

  assign m_tdata = {3'd0, out_channel, param_value, param_index};
endmodule
`default_nettype wire
